// ===== rtl/core/dbch_pkg.sv =====
// ----------------------------------------------------------------------------
// dbch_pkg
// Shared constants and types for the depth band column histogram.
// ----------------------------------------------------------------------------
package dbch_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int NUM_BINS   = 6;
    localparam int NUM_BANDS  = 3;

    localparam int DEPTH_W    = 16;
    localparam int DIM_W      = 12;
    localparam int POS_W      = 11;
    localparam int BINC_W     = 9;
    localparam int BIN_W      = 3;
    localparam int BAND_W     = 2;
    localparam int COUNT_W    = 23;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int ADDR_W     = BIN_W + 1;

    // Reciprocal constants: x/10 and x/6, exact for x up to 2048
    localparam int MUL_W      = 12;
    localparam int PROD_W     = DIM_W + MUL_W;
    localparam int RECIP_SH   = 14;
    localparam logic [MUL_W-1:0] TENTH_MUL = 12'd1639;
    localparam logic [MUL_W-1:0] SIXTH_MUL = 12'd2731;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_SPLIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_SPLIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_LIMIT    = 3'd5;

    // One memory word: the counters of every band for one bin
    typedef logic [NUM_BANDS-1:0][COUNT_W-1:0] count_word_t;

endpackage

// ===== rtl/core/dbch_pixel_if.sv =====
// ----------------------------------------------------------------------------
// dbch_pixel_if
// Depth pixel channel: valid/ready handshake with depth payload.
// ----------------------------------------------------------------------------
interface dbch_pixel_if;
    logic        valid;
    logic        ready;
    logic [15:0] depth_mm;
    logic        depth_valid;

    modport source (output valid, output depth_mm, output depth_valid, input ready);
    modport sink   (input valid, input depth_mm, input depth_valid, output ready);
endinterface

// ===== rtl/core/dbch_result_if.sv =====
// ----------------------------------------------------------------------------
// dbch_result_if
// Histogram result channel: valid/ready handshake with one counter per transfer.
// ----------------------------------------------------------------------------
interface dbch_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  band;
    logic [2:0]  bin;
    logic [22:0] pixel_count;
    logic        last;

    modport source (output valid, output band, output bin, output pixel_count,
                    output last, input ready);
    modport sink   (input valid, input band, input bin, input pixel_count,
                    input last, output ready);
endinterface

// ===== rtl/core/depth_band_column_histogram.sv =====
// ----------------------------------------------------------------------------
// depth_band_column_histogram
// Counts valid depth pixels per column bin in three cumulative depth bands.
// ----------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  pixel    in   valid/ready         depth_mm[15:0], depth_valid
//  result   out  valid/ready         band[1:0], bin[2:0], pixel_count[22:0], last
//  cfg      in   cfg_wr_en           cfg_index[2:0], cfg_data[15:0]
//
//  One pixel per cycle. Counters live in a two-bank memory (one bank per
//  frame, one word per bin); each pixel is a read-modify-write through the
//  update stage, with forwarding between back-to-back pixels of the same bin.
//  After a frame's last pixel, 18 results stream out at one per cycle, while
//  result.ready holds, from the other read port as the next frame is counted.
//  A frame's last pixel stalls only while the previous frame is being read out.
//  Reset (rst_n, async) clears control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module depth_band_column_histogram
    import dbch_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    dbch_pixel_if.sink            pixel,
    dbch_result_if.source         result
);

    // Configuration
    logic [DIM_W-1:0]   frame_width_reg;
    logic [DIM_W-1:0]   frame_height_reg;
    logic [DEPTH_W-1:0] near_limit_reg;
    logic [DEPTH_W-1:0] first_split_reg;
    logic [DEPTH_W-1:0] second_split_reg;
    logic [DEPTH_W-1:0] far_limit_reg;

    // Frame position
    logic [POS_W-1:0]   row_pos_reg;
    logic [POS_W-1:0]   col_pos_reg;
    logic [BIN_W-1:0]   cur_bin_reg;
    logic [BINC_W-1:0]  col_in_bin_reg;
    logic [POS_W-1:0]   row_margin_reg;
    logic [BINC_W-1:0]  bin_cols_reg;
    logic               frame_bank_reg;

    // Update stage
    logic               s1_valid_reg;
    logic               s1_bank_reg;
    logic [BIN_W-1:0]   s1_bin_reg;
    logic [NUM_BANDS-1:0] s1_inc_reg;
    logic               s1_last_reg;
    count_word_t        rd_word_reg;
    logic               rd_ok_reg;

    // Counter memory and per-entry valid bits
    count_word_t        count_mem [2**ADDR_W];
    logic [NUM_BINS-1:0] entry_ok_reg [2];

    // Readout
    logic               drain_busy_reg;
    logic               drain_bank_reg;
    logic [BAND_W-1:0]  drain_band_reg;
    logic [BIN_W-1:0]   drain_bin_reg;
    logic               out_valid_reg;
    logic [BAND_W-1:0]  out_band_reg;
    logic [BIN_W-1:0]   out_bin_reg;
    logic               out_last_reg;
    count_word_t        ob_word_reg;
    logic               ob_ok_reg;

    // Combinational
    logic [DIM_W-1:0]   eff_width;
    logic [DIM_W-1:0]   eff_height;
    logic [PROD_W-1:0]  tenth_prod;
    logic [PROD_W-1:0]  sixth_prod;
    logic [POS_W-1:0]   margin_new;
    logic [BINC_W-1:0]  bin_cols_new;
    logic               frame_start;
    logic [POS_W-1:0]   margin_eff;
    logic [BINC_W-1:0]  bin_cols_eff;
    logic [BIN_W-1:0]   start_bin;
    logic [BIN_W-1:0]   bin_eff;
    logic [BINC_W-1:0]  col_in_bin_eff;
    logic               row_in;
    logic               depth_in_range;
    logic               class0;
    logic               class1;
    logic               class2;
    logic [NUM_BANDS-1:0] inc_mask;
    logic [BIN_W-1:0]   bin_next;
    logic [BINC_W-1:0]  col_in_bin_next;
    logic [BINC_W:0]    col_in_bin_inc;
    logic [DIM_W-1:0]   col_inc;
    logic [DIM_W-1:0]   row_inc;
    logic               col_wrap;
    logic               row_wrap;
    logic               frame_end;
    logic               accept;
    logic               fwd_hit;
    count_word_t        upd_word;
    logic               drain_issue;
    logic               drain_end;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= 12'd672;
            frame_height_reg <= 12'd376;
            near_limit_reg   <= 16'd500;
            first_split_reg  <= 16'd2000;
            second_split_reg <= 16'd3500;
            far_limit_reg    <= 16'd5000;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DIM_W-1:0];
                REG_NEAR_LIMIT:   near_limit_reg   <= cfg_data;
                REG_FIRST_SPLIT:  first_split_reg  <= cfg_data;
                REG_SECOND_SPLIT: second_split_reg <= cfg_data;
                REG_FAR_LIMIT:    far_limit_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Geometry
    // ------------------------------------------------------------------
    always_comb
    begin
        if (frame_width_reg == '0)
            eff_width = DIM_W'(1);
        else if (frame_width_reg > DIM_W'(MAX_WIDTH))
            eff_width = DIM_W'(MAX_WIDTH);
        else
            eff_width = frame_width_reg;

        if (frame_height_reg == '0)
            eff_height = DIM_W'(1);
        else if (frame_height_reg > DIM_W'(MAX_HEIGHT))
            eff_height = DIM_W'(MAX_HEIGHT);
        else
            eff_height = frame_height_reg;
    end

    assign tenth_prod   = PROD_W'(eff_height) * PROD_W'(TENTH_MUL);
    assign sixth_prod   = PROD_W'(eff_width) * PROD_W'(SIXTH_MUL);
    assign margin_new   = POS_W'(tenth_prod[PROD_W-1:RECIP_SH]);
    assign bin_cols_new = sixth_prod[RECIP_SH +: BINC_W];

    assign frame_start    = (row_pos_reg == '0) && (col_pos_reg == '0);
    assign margin_eff     = frame_start ? margin_new : row_margin_reg;
    assign bin_cols_eff   = frame_start ? bin_cols_new : bin_cols_reg;
    assign start_bin      = (bin_cols_eff == '0) ? BIN_W'(NUM_BINS - 1) : '0;
    assign bin_eff        = frame_start ? start_bin : cur_bin_reg;
    assign col_in_bin_eff = frame_start ? '0 : col_in_bin_reg;

    assign row_in = (row_pos_reg >= margin_eff) &&
                    (({1'b0, row_pos_reg} + {1'b0, margin_eff}) < eff_height);

    // ------------------------------------------------------------------
    // Depth classification
    // ------------------------------------------------------------------
    assign depth_in_range = !((pixel.depth_mm < near_limit_reg) ||
                              (pixel.depth_mm > far_limit_reg));
    assign class0 = (pixel.depth_mm > near_limit_reg) &&
                    (pixel.depth_mm < first_split_reg);
    assign class1 = (pixel.depth_mm > first_split_reg) &&
                    (pixel.depth_mm < second_split_reg);
    assign class2 = (pixel.depth_mm > second_split_reg) &&
                    (pixel.depth_mm < far_limit_reg);

    always_comb
    begin
        inc_mask = '0;
        if (pixel.depth_valid && row_in && depth_in_range)
        begin
            if (class0)
                inc_mask = 3'b111;
            else if (class1)
                inc_mask = 3'b110;
            else if (class2)
                inc_mask = 3'b100;
        end
    end

    // ------------------------------------------------------------------
    // Position advance
    // ------------------------------------------------------------------
    always_comb
    begin
        bin_next        = bin_eff;
        col_in_bin_next = col_in_bin_eff;
        col_in_bin_inc  = {1'b0, col_in_bin_eff} + 1'b1;
        if ((bin_cols_eff != '0) && (bin_eff < BIN_W'(NUM_BINS - 1)))
        begin
            if (col_in_bin_inc >= {1'b0, bin_cols_eff})
            begin
                bin_next        = bin_eff + 1'b1;
                col_in_bin_next = '0;
            end
            else
            begin
                col_in_bin_next = col_in_bin_inc[BINC_W-1:0];
            end
        end
    end

    assign col_inc   = {1'b0, col_pos_reg} + 1'b1;
    assign row_inc   = {1'b0, row_pos_reg} + 1'b1;
    assign col_wrap  = col_inc >= eff_width;
    assign row_wrap  = row_inc >= eff_height;
    assign frame_end = col_wrap && row_wrap;

    // Hold the last pixel of a frame while the previous frame still drains
    assign pixel.ready = !(frame_end && (drain_busy_reg || (s1_valid_reg && s1_last_reg)));
    assign accept      = pixel.valid && pixel.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg    <= '0;
            col_pos_reg    <= '0;
            cur_bin_reg    <= '0;
            col_in_bin_reg <= '0;
            row_margin_reg <= POS_W'(37);
            bin_cols_reg   <= BINC_W'(112);
            frame_bank_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (frame_start)
            begin
                row_margin_reg <= margin_new;
                bin_cols_reg   <= bin_cols_new;
            end
            if (col_wrap)
            begin
                col_pos_reg    <= '0;
                row_pos_reg    <= row_wrap ? '0 : row_inc[POS_W-1:0];
                cur_bin_reg    <= start_bin;
                col_in_bin_reg <= '0;
            end
            else
            begin
                col_pos_reg    <= col_inc[POS_W-1:0];
                cur_bin_reg    <= bin_next;
                col_in_bin_reg <= col_in_bin_next;
            end
            if (frame_end)
                frame_bank_reg <= !frame_bank_reg;
        end
    end

    // ------------------------------------------------------------------
    // Read-modify-write of the counter memory
    // ------------------------------------------------------------------
    assign fwd_hit = s1_valid_reg && (s1_bank_reg == frame_bank_reg) &&
                     (s1_bin_reg == bin_eff);

    always_comb
    begin
        for (int b = 0; b < NUM_BANDS; b++)
        begin
            upd_word[b] = rd_ok_reg ? rd_word_reg[b] : '0;
            if (s1_inc_reg[b] && (upd_word[b] != COUNT_MAX))
                upd_word[b] = upd_word[b] + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s1_bank_reg     <= 1'b0;
            s1_bin_reg      <= '0;
            s1_inc_reg      <= '0;
            s1_last_reg     <= 1'b0;
            rd_ok_reg       <= 1'b0;
            entry_ok_reg[0] <= '0;
            entry_ok_reg[1] <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                s1_bank_reg <= frame_bank_reg;
                s1_bin_reg  <= bin_eff;
                s1_inc_reg  <= inc_mask;
                s1_last_reg <= frame_end;
                if (frame_start)
                    rd_ok_reg <= 1'b0;
                else if (fwd_hit)
                    rd_ok_reg <= 1'b1;
                else
                    rd_ok_reg <= entry_ok_reg[frame_bank_reg][bin_eff];
            end
            // Drop the bank's old counts at frame start
            if (accept && frame_start)
                entry_ok_reg[frame_bank_reg] <= '0;
            if (s1_valid_reg)
                entry_ok_reg[s1_bank_reg][s1_bin_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            count_mem[{s1_bank_reg, s1_bin_reg}] <= upd_word;
        if (accept)
            rd_word_reg <= fwd_hit ? upd_word : count_mem[{frame_bank_reg, bin_eff}];
        if (drain_issue)
            ob_word_reg <= count_mem[{drain_bank_reg, drain_bin_reg}];
    end

    // ------------------------------------------------------------------
    // Readout, band-major
    // ------------------------------------------------------------------
    assign drain_issue = drain_busy_reg && (!out_valid_reg || result.ready);
    assign drain_end   = (drain_band_reg == BAND_W'(NUM_BANDS - 1)) &&
                         (drain_bin_reg == BIN_W'(NUM_BINS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_busy_reg <= 1'b0;
            drain_bank_reg <= 1'b0;
            drain_band_reg <= '0;
            drain_bin_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_band_reg   <= '0;
            out_bin_reg    <= '0;
            out_last_reg   <= 1'b0;
            ob_ok_reg      <= 1'b0;
        end
        else
        begin
            // Start once the frame's last write has landed
            if (s1_valid_reg && s1_last_reg)
            begin
                drain_busy_reg <= 1'b1;
                drain_bank_reg <= s1_bank_reg;
                drain_band_reg <= '0;
                drain_bin_reg  <= '0;
            end
            else if (drain_issue)
            begin
                if (drain_bin_reg == BIN_W'(NUM_BINS - 1))
                begin
                    drain_bin_reg <= '0;
                    if (drain_band_reg == BAND_W'(NUM_BANDS - 1))
                        drain_busy_reg <= 1'b0;
                    else
                        drain_band_reg <= drain_band_reg + 1'b1;
                end
                else
                begin
                    drain_bin_reg <= drain_bin_reg + 1'b1;
                end
            end

            if (drain_issue)
            begin
                out_valid_reg <= 1'b1;
                out_band_reg  <= drain_band_reg;
                out_bin_reg   <= drain_bin_reg;
                out_last_reg  <= drain_end;
                ob_ok_reg     <= entry_ok_reg[drain_bank_reg][drain_bin_reg];
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.band        = out_band_reg;
    assign result.bin         = out_bin_reg;
    assign result.last        = out_last_reg;
    assign result.pixel_count = ob_ok_reg ? ob_word_reg[out_band_reg] : '0;

endmodule
